/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MPWL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define MPWL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `MPWL_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* hdl/mpwl_pkg.sv */
// ----------------------------------------------------------------------------
// mpwl_pkg
// Types, register codes and stage sizes of the pixel window/level core.
// ----------------------------------------------------------------------------
package mpwl_pkg;

    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = 8;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STAGES + 1;

    localparam int CFG_DATA_W = 17;
    localparam int LEVEL_W    = 8;
    localparam int WIDTH_W    = 16;
    localparam int REM_W      = WIDTH_W + LEVEL_W;
    localparam int QUO_W      = 35;
    localparam int OFFSET_W   = 27;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    localparam logic [1:0] FMT_GREY8  = 2'd0;
    localparam logic [1:0] FMT_GREY16 = 2'd1;
    localparam logic [1:0] FMT_RGB    = 2'd2;

    typedef enum logic [2:0] {
        CFG_PIXEL_FORMAT      = 3'd0,
        CFG_STORED_BITS       = 3'd1,
        CFG_HIGH_BIT          = 3'd2,
        CFG_IS_SIGNED         = 3'd3,
        CFG_RESCALE_SLOPE     = 3'd4,
        CFG_RESCALE_INTERCEPT = 3'd5,
        CFG_WINDOW_CENTER     = 3'd6,
        CFG_WINDOW_WIDTH      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] level_or_red;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pixel_out;

    typedef struct packed {
        logic [1:0]          pixel_format;
        logic [4:0]          stored_bits;
        logic [3:0]          high_bit;
        logic                is_signed;
        logic signed [15:0]  rescale_slope;
        logic signed [15:0]  rescale_intercept;
        logic signed [16:0]  window_center;
        logic [WIDTH_W-1:0]  window_width;
    } t_cfg;

    typedef struct packed {
        logic [WIDTH_W-1:0]         w_eff;
        logic signed [OFFSET_W-1:0] offset;
    } t_cfg_drv;

    typedef struct packed {
        logic      rgb;
        t_pixel_in pix;
    } t_tag;

    typedef struct packed {
        logic               valid;
        t_tag               tag;
        logic               zero;
        logic               sat;
        logic [REM_W-1:0]   rem;
        logic [LEVEL_W-1:0] quo;
    } t_div_stage;

endpackage

/* hdl/mpwl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mpwl_cfg_regs
// Configuration register file and registered window terms.
// ----------------------------------------------------------------------------
module mpwl_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  mpwl_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [mpwl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output mpwl_pkg::t_cfg                       o_cfg,
    output mpwl_pkg::t_cfg_drv                   o_drv
);
    import mpwl_pkg::*;

    t_cfg                r_cfg;
    t_cfg                n_cfg;
    t_cfg_drv            r_drv;
    t_cfg_drv            n_drv;
    logic [WIDTH_W-1:0]  w_eff;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_FORMAT:      n_cfg.pixel_format      = i_cfg_data[1:0];
                CFG_STORED_BITS:       n_cfg.stored_bits       = i_cfg_data[4:0];
                CFG_HIGH_BIT:          n_cfg.high_bit          = i_cfg_data[3:0];
                CFG_IS_SIGNED:         n_cfg.is_signed         = i_cfg_data[0];
                CFG_RESCALE_SLOPE:     n_cfg.rescale_slope     = $signed(i_cfg_data[15:0]);
                CFG_RESCALE_INTERCEPT: n_cfg.rescale_intercept = $signed(i_cfg_data[15:0]);
                CFG_WINDOW_CENTER:     n_cfg.window_center     = $signed(i_cfg_data[16:0]);
                CFG_WINDOW_WIDTH:      n_cfg.window_width      = i_cfg_data[15:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    // Zero width acts as one; offset = 256 * width - 512 * center.
    always_comb begin
        w_eff        = (r_cfg.window_width == '0) ? 16'd1 : r_cfg.window_width;
        n_drv.w_eff  = w_eff;
        n_drv.offset = $signed({3'b000, w_eff, 8'h00})
                     - $signed({r_cfg.window_center[16], r_cfg.window_center, 9'h000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format      <= FMT_GREY8;
            r_cfg.stored_bits       <= 5'd16;
            r_cfg.high_bit          <= 4'd15;
            r_cfg.is_signed         <= 1'b0;
            r_cfg.rescale_slope     <= 16'sd256;
            r_cfg.rescale_intercept <= 16'sd0;
            r_cfg.window_center     <= 17'sd128;
            r_cfg.window_width      <= 16'd256;
            r_drv.w_eff             <= 16'd256;
            r_drv.offset            <= '0;
        end else begin
            r_cfg <= n_cfg;
            r_drv <= n_drv;
        end
    end

    assign o_cfg = r_cfg;
    assign o_drv = r_drv;

endmodule

/* hdl/mpwl_front.sv */
// ----------------------------------------------------------------------------
// mpwl_front
// Sample extraction, rescale and window numerator, six register stages.
// ----------------------------------------------------------------------------
module mpwl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mpwl_pkg::t_pixel_in  i_pixel,
    input  mpwl_pkg::t_cfg       i_cfg,
    input  mpwl_pkg::t_cfg_drv   i_drv,
    output mpwl_pkg::t_div_stage o_div
);
    import mpwl_pkg::*;

    logic [FRONT_STAGES-1:0] r_valid;
    t_tag                    r_tag [FRONT_STAGES];

    logic                    wide;
    logic                    is_rgb;
    logic                    use_full;
    logic                    use_shift;
    logic [15:0]             raw;
    logic [15:0]             lifted;
    logic [4:0]              full_w;
    logic [4:0]              n_keep;
    logic [4:0]              sh_keep;
    logic [4:0]              sh_k;
    logic signed [16:0]      kept_s;
    logic signed [16:0]      shifted_s;
    logic signed [16:0]      n_sample;
    logic [43:0]             n_scaled;

    logic signed [16:0]      r_sample;
    logic signed [32:0]      r_prod;
    logic signed [33:0]      r_sum;
    logic [35:0]             r_num;
    logic [QUO_W-1:0]        r_quo;
    logic                    r_zero5;
    logic                    r_zero6;
    logic                    r_sat;
    logic [REM_W-1:0]        r_rem;

    // Stage 1: extract the stored bits.
    always_comb begin
        wide      = (i_cfg.pixel_format == FMT_GREY16);
        is_rgb    = (i_cfg.pixel_format >= FMT_RGB);
        raw       = wide ? {i_pixel.byte_b, i_pixel.byte_a} : {8'h00, i_pixel.byte_a};
        full_w    = wide ? 5'd16 : 5'd8;
        use_full  = (i_cfg.stored_bits >= full_w) || (!wide && (i_cfg.high_bit >= 4'd7));
        use_shift = !use_full && wide && (i_cfg.high_bit == 4'd15);
        n_keep    = use_full ? full_w : i_cfg.stored_bits;
        sh_keep   = 5'd16 - n_keep;
        lifted    = raw << sh_keep[3:0];
        if (n_keep == '0) begin
            kept_s = '0;
        end else if (i_cfg.is_signed) begin
            kept_s = $signed({lifted[15], lifted}) >>> sh_keep;
        end else begin
            kept_s = $signed({1'b0, lifted} >> sh_keep);
        end
        sh_k      = 5'd16 - i_cfg.stored_bits;
        shifted_s = $signed({i_cfg.is_signed & raw[15], raw}) >>> sh_k;
        n_sample  = use_shift ? shifted_s : kept_s;
    end

    // Stage 5 product by 255, then drop the 512 of the divisor.
    assign n_scaled = {r_num, 8'h00} - {8'h00, r_num};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= '{rgb: is_rgb, pix: i_pixel};
        for (int s = 1; s < FRONT_STAGES; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        r_sample <= n_sample;
        r_prod   <= r_sample * i_cfg.rescale_slope;
        r_sum    <= $signed({r_prod[32], r_prod})
                  + $signed({{10{i_cfg.rescale_intercept[15]}}, i_cfg.rescale_intercept, 8'h00});
        r_num    <= {r_sum[33], r_sum, 1'b0}
                  + {{(36 - OFFSET_W){i_drv.offset[OFFSET_W-1]}}, i_drv.offset};
        r_zero5  <= r_num[35] || (r_num == '0);
        r_quo    <= n_scaled[43:9];
        r_zero6  <= r_zero5;
        r_sat    <= r_quo >= {{(QUO_W - REM_W){1'b0}}, i_drv.w_eff, 8'h00};
        r_rem    <= r_quo[REM_W-1:0];
    end

    always_comb begin
        o_div.valid = r_valid[FRONT_STAGES-1];
        o_div.tag   = r_tag[FRONT_STAGES-1];
        o_div.zero  = r_zero6;
        o_div.sat   = r_sat;
        o_div.rem   = r_rem;
        o_div.quo   = '0;
    end

endmodule

/* hdl/mpwl_div.sv */
// ----------------------------------------------------------------------------
// mpwl_div
// Restoring divider, one quotient bit per stage, and the result register.
// ----------------------------------------------------------------------------
module mpwl_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpwl_pkg::t_div_stage                i_div,
    input  logic [mpwl_pkg::WIDTH_W-1:0]        i_w,
    output logic                                o_done,
    output mpwl_pkg::t_pixel_out                o_result
);
    import mpwl_pkg::*;

    t_div_stage  r_stage [DIV_STAGES];
    t_div_stage  in_stage [DIV_STAGES];
    t_div_stage  n_stage [DIV_STAGES];
    logic        r_done;
    t_pixel_out  r_result;
    t_pixel_out  n_result;

    always_comb begin
        logic [REM_W-1:0] dsr;
        logic             hit;
        in_stage[0] = i_div;
        for (int s = 1; s < DIV_STAGES; s++) begin
            in_stage[s] = r_stage[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            dsr        = {{LEVEL_W{1'b0}}, i_w} << (DIV_STAGES - 1 - s);
            hit        = in_stage[s].rem >= dsr;
            n_stage[s] = in_stage[s];
            if (hit) begin
                n_stage[s].rem = in_stage[s].rem - dsr;
            end
            n_stage[s].quo = in_stage[s].quo
                           | (LEVEL_W'(hit) << (DIV_STAGES - 1 - s));
        end
    end

    always_comb begin
        n_result = '0;
        if (r_stage[DIV_STAGES-1].tag.rgb) begin
            n_result.level_or_red = r_stage[DIV_STAGES-1].tag.pix.byte_a;
            n_result.green_out    = r_stage[DIV_STAGES-1].tag.pix.byte_b;
            n_result.blue_out     = r_stage[DIV_STAGES-1].tag.pix.byte_c;
        end else if (r_stage[DIV_STAGES-1].zero) begin
            n_result.level_or_red = '0;
        end else if (r_stage[DIV_STAGES-1].sat) begin
            n_result.level_or_red = LEVEL_MAX;
        end else begin
            n_result.level_or_red = r_stage[DIV_STAGES-1].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_stage[s] <= '0;
            end
            r_done <= 1'b0;
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_stage[s] <= n_stage[s];
            end
            r_done <= r_stage[DIV_STAGES-1].valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* hdl/medical_pixel_window_level_core.sv */
// ----------------------------------------------------------------------------
// medical_pixel_window_level_core
// Grey pixel rescale and window/level to 8 bits; colour pixels pass through.
// ----------------------------------------------------------------------------
// Channel   Signals                            Transfer
// request   start, busy, i_pixel               taken when start=1 and busy=0
// result    o_done, o_result                   o_done high for one cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data    written when i_cfg_we=1
//
// One request per clock; each result passes through the stages listed below.
// Path: six front stages (extract, multiply, intercept, offset, scale,
// saturate), eight divider stages of one quotient bit each, one output stage.
// busy is high only while reset is asserted; reset clears all valid bits.
// Nothing stalls: results cannot be held off, so every stage advances each clock.
// Window terms are derived from the configuration registers and registered again.
// ----------------------------------------------------------------------------
module medical_pixel_window_level_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mpwl_pkg::t_pixel_in              i_pixel,
    output logic                             o_done,
    output mpwl_pkg::t_pixel_out             o_result,
    input  logic                             i_cfg_we,
    input  mpwl_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [mpwl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpwl_pkg::*;

    t_cfg       cfg;
    t_cfg_drv   drv;
    t_div_stage div_in;
    logic       accept;

    assign busy   = !i_rst_n;
    assign accept = start && i_rst_n;

    mpwl_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_drv      (drv)
    );

    mpwl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pixel (i_pixel),
        .i_cfg   (cfg),
        .i_drv   (drv),
        .o_div   (div_in)
    );

    mpwl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_div    (div_in),
        .i_w      (drv.w_eff),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

/* hdl/mpwl_checker.sv */
// ----------------------------------------------------------------------------
// mpwl_checker
// Port-level checks of request/result timing, grey colour planes and colour pass-through.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpwl_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  mpwl_pkg::t_pixel_in              i_pixel,
    input  logic                             o_done,
    input  mpwl_pkg::t_pixel_out             o_result,
    input  logic                             i_cfg_we,
    input  mpwl_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [mpwl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpwl_pkg::*;

    logic [1:0] r_fmt;

    // Track the pixel format seen on the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_GREY8;
        end else if (i_cfg_we && (i_cfg_idx == CFG_PIXEL_FORMAT)) begin
            r_fmt <= i_cfg_data[1:0];
        end
    end

    `MPWL_ASSERT(a_request_gives_result, i_clk, i_rst_n, (start && !busy) |-> ##PIPE_LATENCY o_done, "request without result")
    `MPWL_ASSERT_IMPLY(a_result_has_request, i_clk, i_rst_n, o_done, $past(start && !busy, PIPE_LATENCY), "result without request")
    `MPWL_ASSERT_IMPLY(a_grey_zero_planes, i_clk, i_rst_n, o_done && (r_fmt < FMT_RGB), (o_result.green_out == '0) && (o_result.blue_out == '0), "grey result with colour planes")
    `MPWL_ASSERT_IMPLY(a_rgb_pass, i_clk, i_rst_n, o_done && (r_fmt >= FMT_RGB), (o_result.level_or_red == $past(i_pixel.byte_a, PIPE_LATENCY)) && (o_result.green_out == $past(i_pixel.byte_b, PIPE_LATENCY)) && (o_result.blue_out == $past(i_pixel.byte_c, PIPE_LATENCY)), "colour pixel altered")

endmodule

bind medical_pixel_window_level_core mpwl_checker u_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel window/level core testbench
// Loads register settings while the pipeline is empty, then streams grey and
// colour pixels through the core. A scoreboard predicts the extracted,
// rescaled and windowed level of every grey request and the unchanged bytes of
// every colour request, and compares each result in order.
// ----------------------------------------------------------------------------
module testbench;
    import mpwl_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RAND_PHASES  = 12;
    localparam int RAND_PER_SET = 78;

    class pixel_scoreboard;
        t_pixel_out  expected_pixels[$];
        int          mismatches;
        int          requests_seen;
        int          results_seen;
        logic [1:0]  fmt;
        int          bits_stored;
        int          top_bit;
        bit          fmt_signed;
        longint      slope;
        longint      intercept;
        longint      center;
        longint      level_span;

        function new();
            fmt         = FMT_GREY8;
            bits_stored = 16;
            top_bit     = 15;
            fmt_signed  = 1'b0;
            slope       = 256;
            intercept   = 0;
            center      = 128;
            level_span  = 256;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_PIXEL_FORMAT:      fmt = d[1:0];
                CFG_STORED_BITS:       bits_stored = d[4:0];
                CFG_HIGH_BIT:          top_bit = d[3:0];
                CFG_IS_SIGNED:         fmt_signed = d[0];
                CFG_RESCALE_SLOPE:     slope = $signed(d[15:0]);
                CFG_RESCALE_INTERCEPT: intercept = $signed(d[15:0]);
                CFG_WINDOW_CENTER:     center = $signed(d[16:0]);
                default:               level_span = d[15:0];
            endcase
        endfunction

        function longint sign_ext(longint v, int bits);
            longint top;
            top = longint'(1) << (bits - 1);
            v = v & ((top << 1) - 1);
            return ((v & top) != 0) ? v - (top << 1) : v;
        endfunction

        function longint stored_sample(longint raw, int width);
            int     k;
            longint s;
            if (bits_stored >= width)
                return fmt_signed ? sign_ext(raw, width) : raw;
            k = width - bits_stored;
            if (top_bit < width - 1) begin
                if (bits_stored == 0)
                    return 0;
                s = raw & ((longint'(1) << bits_stored) - 1);
                return fmt_signed ? sign_ext(s, bits_stored) : s;
            end
            if (width == 8)
                return fmt_signed ? sign_ext(raw, 8) : raw;
            if (!fmt_signed)
                return raw >> k;
            s = sign_ext(raw, 16);
            if (s >= 0)
                return s >> k;
            return -((-s - 1) >> k) - 1;
        endfunction

        function logic [7:0] windowed_level(longint v);
            longint w;
            longint num;
            longint q;
            w = (level_span == 0) ? 1 : level_span;
            num = 2 * (v * slope + intercept * 256) - 512 * center + 256 * w;
            if (num <= 0)
                return 8'd0;
            q = (num * 255) / (512 * w);
            return (q > 255) ? LEVEL_MAX : q[7:0];
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task note_pixel(t_pixel_in p);
            t_pixel_out e;
            requests_seen++;
            if (fmt >= FMT_RGB) begin
                e = {p.byte_a, p.byte_b, p.byte_c};
            end else begin
                if (fmt == FMT_GREY16)
                    e.level_or_red = windowed_level(stored_sample({p.byte_b, p.byte_a}, 16));
                else
                    e.level_or_red = windowed_level(stored_sample(p.byte_a, 8));
                e.green_out = '0;
                e.blue_out  = '0;
            end
            expected_pixels.push_back(e);
        endtask

        task check_pixel(t_pixel_out got);
            t_pixel_out want;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report($sformatf("result %h with no request pending", got));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.level_or_red !== want.level_or_red)
                report($sformatf("level_or_red %h, want %h", got.level_or_red,
                                 want.level_or_red));
            if (got.green_out !== want.green_out)
                report($sformatf("green_out %h, want %h", got.green_out, want.green_out));
            if (got.blue_out !== want.blue_out)
                report($sformatf("blue_out %h, want %h", got.blue_out, want.blue_out));
        endtask

        task flush_leftovers();
            if (expected_pixels.size() != 0)
                report($sformatf("%0d results never arrived", expected_pixels.size()));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_pixel_in             i_pixel;
    logic                  o_done;
    t_pixel_out            o_result;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pixel_scoreboard sb;
    int              cycle_count = 0;
    int              settings_loaded = 0;
    int              idle_pct_by_phase[4] = '{0, 65, 0, 32};
    logic [7:0]      corner_bytes[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};

    medical_pixel_window_level_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_pixel(o_result);
    end

    function automatic t_cfg pack_setting(int fmt, int nbits, int hbit, int sgn, int slope,
                                          int icpt, int ctr, int wid);
        t_cfg c;
        c.pixel_format      = 2'(fmt);
        c.stored_bits       = 5'(nbits);
        c.high_bit          = 4'(hbit);
        c.is_signed         = 1'(sgn);
        c.rescale_slope     = 16'(slope);
        c.rescale_intercept = 16'(icpt);
        c.window_center     = 17'(ctr);
        c.window_width      = 16'(wid);
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        int   sel;
        int   bits;
        int   slope_abs;
        int   rs;
        c.pixel_format = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                                     : 2'($urandom_range(0, 1));
        c.is_signed = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0)
            c.stored_bits = 5'($urandom_range(0, 31));
        else
            c.stored_bits = 5'($urandom_range(1, (c.pixel_format == FMT_GREY8) ? 8 : 16));
        sel = $urandom_range(0, 2);
        if (sel == 0)
            c.high_bit = 4'(c.stored_bits - 1);
        else if (sel == 1)
            c.high_bit = (c.pixel_format == FMT_GREY8) ? 4'd7 : 4'd15;
        else
            c.high_bit = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) begin
            c.rescale_slope     = 16'($urandom);
            c.rescale_intercept = 16'($urandom);
            c.window_center     = 17'($urandom);
            c.window_width      = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        end else begin
            slope_abs = $urandom_range(16, 1024);
            c.rescale_slope = ($urandom_range(0, 3) == 0) ? 16'(-slope_abs) : 16'(slope_abs);
            c.rescale_intercept = 16'(int'($urandom_range(0, 512)) - 256);
            bits = (c.stored_bits == 0 || c.stored_bits > 16) ? 16 : c.stored_bits;
            rs = ((1 << bits) * slope_abs) >> 8;
            if (rs < 2)
                rs = 2;
            if (rs > 65535)
                rs = 65535;
            c.window_center = 17'(int'($urandom_range(0, 2 * rs)) - rs);
            c.window_width  = 16'($urandom_range(1, rs));
        end
        return c;
    endfunction

    task automatic drain_pipe();
        while (sb.expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic load_setting(input t_cfg c);
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] word;
        drain_pipe();
        for (int i = 0; i < 8; i++) begin
            idx = t_cfg_idx'(i);
            case (idx)
                CFG_PIXEL_FORMAT:      word = CFG_DATA_W'(c.pixel_format);
                CFG_STORED_BITS:       word = CFG_DATA_W'(c.stored_bits);
                CFG_HIGH_BIT:          word = CFG_DATA_W'(c.high_bit);
                CFG_IS_SIGNED:         word = CFG_DATA_W'(c.is_signed);
                CFG_RESCALE_SLOPE:     word = {1'b0, c.rescale_slope};
                CFG_RESCALE_INTERCEPT: word = {1'b0, c.rescale_intercept};
                CFG_WINDOW_CENTER:     word = c.window_center;
                default:               word = {1'b0, c.window_width};
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= word;
            @(posedge i_clk);
            sb.set_reg(idx, word);
        end
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
        settings_loaded++;
    endtask

    task automatic send_pixel(input t_pixel_in p);
        start   <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(p);
    endtask

    task automatic send_batch(input t_pixel_in batch[$], input int idle_pct);
        foreach (batch[n]) begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                start   <= 1'b0;
                i_pixel <= 24'($urandom);
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            send_pixel(batch[n]);
        end
        start <= 1'b0;
    endtask

    initial begin
        t_pixel_in batch[$];
        t_pixel_in p;
        sb = new();
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_pixel    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_PIXEL_FORMAT;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register values straight out of reset
        batch = '{24'h00AA55, 24'hFF00FF, 24'h80FF00, 24'h7F1234};
        send_batch(batch, 0);

        load_setting(pack_setting(FMT_GREY16, 16, 15, 0, 256, 0, 32768, 65535));
        batch = '{24'h000000, 24'hFFFF00, 24'h008000};
        send_batch(batch, 0);

        // sign-extend the kept low bits, extreme rescale, narrowest window
        load_setting(pack_setting(FMT_GREY16, 12, 11, 1, -32768, 32767, -65536, 1));
        batch = '{24'hFF0700, 24'h000800, 24'hFFFFFF};
        send_batch(batch, 0);

        // arithmetic shift at the top bit, zero width acts as one
        load_setting(pack_setting(FMT_GREY16, 12, 15, 1, 32767, -32768, 65535, 0));
        batch = '{24'h008000, 24'hFF7F00, 24'hF0FF00};
        send_batch(batch, 0);

        // no stored bits: full shift leaves only the sign
        load_setting(pack_setting(FMT_GREY16, 0, 15, 1, 256, 0, 0, 4));
        batch = '{24'h008000, 24'h010000};
        send_batch(batch, 0);

        load_setting(pack_setting(FMT_GREY8, 0, 3, 1, 256, 0, 0, 4));
        batch = '{24'hFFFFFF};
        send_batch(batch, 0);

        load_setting(pack_setting(FMT_GREY8, 4, 3, 1, 512, -10, 0, 32));
        batch = '{24'h0FAA00, 24'h085500, 24'hF7FFFF};
        send_batch(batch, 0);

        load_setting(pack_setting(FMT_GREY8, 31, 7, 1, 256, 0, 0, 256));
        batch = '{24'h800000, 24'h7FFFFF};
        send_batch(batch, 0);

        load_setting(pack_setting(FMT_RGB, 8, 7, 0, 256, 0, 128, 256));
        batch = '{24'h123456};
        send_batch(batch, 0);

        // unused format code passes colour through
        load_setting(pack_setting(3, 8, 7, 0, 256, 0, 128, 256));
        batch = '{24'h00FF80, 24'hFF007F};
        send_batch(batch, 0);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            load_setting(random_cfg());
            batch.delete();
            repeat (RAND_PER_SET) begin
                if ($urandom_range(0, 9) == 0) begin
                    p.byte_a = corner_bytes[$urandom_range(0, 3)];
                    p.byte_b = corner_bytes[$urandom_range(0, 3)];
                    p.byte_c = corner_bytes[$urandom_range(0, 3)];
                end else begin
                    p = 24'($urandom);
                end
                batch.push_back(p);
            end
            send_batch(batch, idle_pct_by_phase[phase % 4]);
        end

        while (sb.expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        sb.flush_leftovers();
        $display("Streamed %0d pixel requests across %0d register settings.",
                 sb.requests_seen, settings_loaded);
        $display("Compared %0d results; %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
